FILE: hw/rtl/grid_min_edge_length_defines.svh
// assertion helpers for the grid min edge length block
`ifndef GRID_MIN_EDGE_LENGTH_DEFINES_SVH
`define GRID_MIN_EDGE_LENGTH_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GMEL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GMEL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gmel_pkg.sv
`timescale 1ns / 1ps

package gmel_pkg;

    localparam int COORD_BITS      = 24;
    localparam int MAX_PLANE_NODES = 4096;
    localparam int ADDR_W          = $clog2(MAX_PLANE_NODES);

    localparam int CX_W      = 10;
    localparam int CY_W      = 6;
    localparam int CZ_W      = 6;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int SQ2_W     = 2 * DIFF_W;
    localparam int SQ_W      = 50;
    localparam int MAG_LIM_W = 25;
    localparam int SUM_W     = (SQ2_W + 2 > SQ_W + 1) ? SQ2_W + 2 : SQ_W + 1;
    localparam int LEN_W     = 25;

    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_vtx;

    localparam int VTX_W = $bits(t_vtx);

    // one classified vertex on its way from front to back
    typedef struct packed {
        t_vtx              vtx;
        logic [ADDR_W-1:0] slot;
        logic [ADDR_W-1:0] zslot;
        logic              en_y;
        logic              en_z;
        logic              en_x;
        logic              first;
        logic              last;
    } t_item;

endpackage

FILE: hw/rtl/gmel_ram.sv
`timescale 1ns / 1ps

module gmel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: hw/rtl/gmel_isqrt.sv
`timescale 1ns / 1ps

module gmel_isqrt
    import gmel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_radicand,
    output logic             o_done,
    output logic [LEN_W-1:0] o_root
);

    localparam int REM_W = LEN_W + 3;
    localparam int CNT_W = $clog2(LEN_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_rad;
    logic [REM_W-1:0] r_rem;
    logic [LEN_W-1:0] r_root;

    logic [REM_W-1:0] n_rem_sh;
    logic [REM_W-1:0] n_trial;
    logic             n_fit;

    // one result bit per cycle, two radicand bits shifted in each step
    always_comb begin
        n_rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1 -: 2]};
        n_trial  = REM_W'({r_root, 2'b01});
        n_fit    = n_rem_sh >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(LEN_W - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= n_fit ? n_rem_sh - n_trial : n_rem_sh;
            r_root <= {r_root[LEN_W-2:0], n_fit};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/gmel_front.sv
`timescale 1ns / 1ps

module gmel_front
    import gmel_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic                         i_push,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output t_item                        o_q_item
);

    logic [CX_W-1:0]   r_cells_x;
    logic [CY_W-1:0]   r_cells_y;
    logic [CZ_W-1:0]   r_cells_z;
    logic [CX_W-1:0]   r_idx_x;
    logic [CY_W-1:0]   r_idx_y;
    logic [CZ_W-1:0]   r_idx_z;
    logic [ADDR_W-1:0] r_slot;

    logic n_accept;
    logic n_last;
    logic n_cfg_hit;

    always_comb begin
        n_accept  = i_push && !i_q_full;
        n_last    = (r_idx_y >= r_cells_y) && (r_idx_z >= r_cells_z) && (r_idx_x >= r_cells_x);
        n_cfg_hit = i_cfg_we && (i_cfg_addr == CFG_CELLS_X || i_cfg_addr == CFG_CELLS_Y ||
                                 i_cfg_addr == CFG_CELLS_Z);

        o_q_item.vtx.x = i_pos_x;
        o_q_item.vtx.y = i_pos_y;
        o_q_item.vtx.z = i_pos_z;
        o_q_item.slot  = r_slot;
        // z neighbour sits one y column back in the plane store
        o_q_item.zslot = r_slot - (ADDR_W'(r_cells_y) + ADDR_W'(1));
        o_q_item.en_y  = r_idx_y != '0;
        o_q_item.en_z  = r_idx_z != '0;
        o_q_item.en_x  = r_idx_x != '0;
        o_q_item.first = (r_idx_y == '0) && (r_idx_z == '0) && (r_idx_x == '0);
        o_q_item.last  = n_last;
    end

    assign o_q_push = n_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= '0;
            r_cells_y <= '0;
            r_cells_z <= '0;
            r_idx_x   <= '0;
            r_idx_y   <= '0;
            r_idx_z   <= '0;
            r_slot    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CELLS_X: r_cells_x <= i_cfg_wdata[CX_W-1:0];
                CFG_CELLS_Y: r_cells_y <= i_cfg_wdata[CY_W-1:0];
                CFG_CELLS_Z: r_cells_z <= i_cfg_wdata[CZ_W-1:0];
                default: ;
            endcase
            // any known register write starts a new grid
            if (n_cfg_hit) begin
                r_idx_x <= '0;
                r_idx_y <= '0;
                r_idx_z <= '0;
                r_slot  <= '0;
            end
        end else if (n_accept) begin
            priority if (n_last) begin
                r_idx_x <= '0;
                r_idx_y <= '0;
                r_idx_z <= '0;
                r_slot  <= '0;
            end else if (r_idx_y >= r_cells_y) begin
                r_idx_y <= '0;
                if (r_idx_z >= r_cells_z) begin
                    r_idx_z <= '0;
                    r_idx_x <= r_idx_x + 1'b1;
                    r_slot  <= '0;
                end else begin
                    r_idx_z <= r_idx_z + 1'b1;
                    r_slot  <= r_slot + 1'b1;
                end
            end else begin
                r_idx_y <= r_idx_y + 1'b1;
                r_slot  <= r_slot + 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/gmel_queue.sv
`timescale 1ns / 1ps

module gmel_queue
    import gmel_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    logic n_wr;
    logic n_rd;

    always_comb begin
        o_full  = r_count == Q_CNT_W'(QUEUE_DEPTH);
        o_empty = r_count == '0;
        n_wr    = i_push && !o_full;
        n_rd    = i_pop && !o_empty;
        o_item  = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (n_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (n_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (n_wr && !n_rd) begin
                r_count <= r_count + 1'b1;
            end else if (n_rd && !n_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/gmel_back.sv
`timescale 1ns / 1ps
`include "grid_min_edge_length_defines.svh"

module gmel_back
    import gmel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [LEN_W-1:0] o_min_edge_length,
    output logic             o_has_edge
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIST,
        S_CHECK,
        S_SQRT,
        S_EMIT
    } t_state;

    localparam logic [1:0] NB_Y = 2'd0;
    localparam logic [1:0] NB_Z = 2'd1;
    localparam logic [1:0] NB_X = 2'd2;
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    function automatic logic [COORD_BITS-1:0] f_coord(input t_vtx v, input logic [1:0] ax);
        logic [COORD_BITS-1:0] c;
        unique case (ax)
            AX_X:    c = v.x;
            AX_Y:    c = v.y;
            default: c = v.z;
        endcase
        return c;
    endfunction

    t_state           r_state;
    logic             r_issue;
    logic [1:0]       r_nb;
    logic [1:0]       r_ax;
    logic             r_v1;
    logic             r_v2;
    logic [SQ_W-1:0]  r_min;
    logic             r_edge;
    logic [LEN_W-1:0] r_len;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_edge;

    t_item             r_item;
    t_vtx              r_prev;
    t_vtx              r_nb_y;
    t_vtx              r_nb_z;
    t_vtx              r_nb_x;
    logic [DIFF_W-1:0] r_mag1;
    logic              r_big1;
    logic [1:0]        r_nb1;
    logic [1:0]        r_ax1;
    logic [SQ2_W-1:0]  r_sq2;
    logic              r_big2;
    logic [1:0]        r_nb2;
    logic [1:0]        r_ax2;
    logic [SUM_W-1:0]  r_acc;
    logic              r_big_acc;

    logic [VTX_W-1:0]      w_rdata_a;
    logic [VTX_W-1:0]      w_rdata_b;
    logic                  w_sq_start;
    logic                  w_sq_done;
    logic [LEN_W-1:0]      w_sq_root;

    t_vtx                  n_nbv;
    logic [COORD_BITS-1:0] n_cc;
    logic [COORD_BITS-1:0] n_nc;
    logic [DIFF_W-1:0]     n_diff;
    logic [DIFF_W-1:0]     n_mag;
    logic                  n_big;
    logic [SQ2_W-1:0]      n_sq;
    logic [SUM_W-1:0]      n_sum;
    logic                  n_big_sum;
    logic [SQ_W-1:0]       n_dist;
    logic                  n_nb_en;
    logic                  n_pair_end;

    gmel_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_PLANE_NODES)
    ) u_plane (
        .i_clk     (i_clk),
        .i_we      (r_state == S_LOAD),
        .i_waddr   (r_item.slot),
        .i_wdata   (r_item.vtx),
        .i_raddr_a (i_q_item.slot),
        .i_raddr_b (i_q_item.zslot),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_sq_start = (r_state == S_CHECK) && r_edge;

    gmel_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_min),
        .o_done     (w_sq_done),
        .o_root     (w_sq_root)
    );

    always_comb begin
        // stage 1: one axis of one neighbour pair
        unique case (r_nb)
            NB_Y:    n_nbv = r_nb_y;
            NB_Z:    n_nbv = r_nb_z;
            NB_X:    n_nbv = r_nb_x;
            default: n_nbv = r_nb_y;
        endcase
        n_cc   = f_coord(r_item.vtx, r_ax);
        n_nc   = f_coord(n_nbv, r_ax);
        n_diff = {n_cc[COORD_BITS-1], n_cc} - {n_nc[COORD_BITS-1], n_nc};
        n_mag  = n_diff[DIFF_W-1] ? (~n_diff + 1'b1) : n_diff;
        n_big  = |(n_mag >> MAG_LIM_W);

        // stage 2: square
        n_sq = SQ2_W'(r_mag1) * SQ2_W'(r_mag1);

        // stage 3: accumulate over the three axes, saturate, compare
        n_sum      = SUM_W'(r_sq2) + ((r_ax2 == AX_X) ? '0 : r_acc);
        n_big_sum  = r_big2 || ((r_ax2 != AX_X) && r_big_acc);
        n_dist     = (n_big_sum || n_sum > SUM_W'(SQ_MAX)) ? SQ_MAX : n_sum[SQ_W-1:0];
        n_pair_end = r_v2 && (r_ax2 == AX_Z);
        unique case (r_nb2)
            NB_Y:    n_nb_en = r_item.en_y;
            NB_Z:    n_nb_en = r_item.en_z;
            NB_X:    n_nb_en = r_item.en_x;
            default: n_nb_en = 1'b0;
        endcase
    end

    assign o_q_pop           = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty           = !r_out_valid;
    assign o_min_edge_length = r_out_len;
    assign o_has_edge        = r_out_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_nb        <= NB_Y;
            r_ax        <= AX_X;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_min       <= SQ_MAX;
            r_edge      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            if (r_issue) begin
                if (r_ax == AX_Z) begin
                    r_ax <= AX_X;
                    if (r_nb == NB_X) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_nb <= r_nb + 1'b1;
                    end
                end else begin
                    r_ax <= r_ax + 1'b1;
                end
            end
            if (n_pair_end && n_nb_en) begin
                r_edge <= 1'b1;
                if (n_dist < r_min) begin
                    r_min <= n_dist;
                end
            end
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_q_item.first) begin
                            r_min  <= SQ_MAX;
                            r_edge <= 1'b0;
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_issue <= 1'b1;
                    r_nb    <= NB_Y;
                    r_ax    <= AX_X;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    if (n_pair_end && r_nb2 == NB_X) begin
                        r_state <= r_item.last ? S_CHECK : S_IDLE;
                    end
                end
                S_CHECK: begin
                    if (r_edge) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_len   <= LEN_MAX;
                        r_state <= S_EMIT;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_len   <= w_sq_root;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // wait until the previous result has been transferred
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_len   <= r_len;
                        r_out_edge  <= r_edge;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_q_empty) begin
            r_item <= i_q_item;
        end
        if (r_state == S_LOAD) begin
            r_nb_x <= w_rdata_a;
            r_nb_z <= w_rdata_b;
            r_nb_y <= r_prev;
            r_prev <= r_item.vtx;
        end
        r_mag1 <= n_mag;
        r_big1 <= n_big;
        r_nb1  <= r_nb;
        r_ax1  <= r_ax;
        r_sq2  <= n_sq;
        r_big2 <= r_big1;
        r_nb2  <= r_nb1;
        r_ax2  <= r_ax1;
        if (r_v2) begin
            r_acc     <= n_sum;
            r_big_acc <= n_big_sum;
        end
    end

    `GMEL_ASSERT_NEXT(a_emit_loads_result, i_clk, i_rst_n, (r_state == S_EMIT) && !r_out_valid, r_out_valid && (r_state == S_IDLE), "result not loaded on emit")
    `GMEL_ASSERT_IMPL(a_root_only_in_sqrt, i_clk, i_rst_n, w_sq_done, r_state == S_SQRT, "square root finished outside its wait state")
    `GMEL_ASSERT_NEXT(a_min_never_rises, i_clk, i_rst_n, r_state != S_IDLE, r_min <= $past(r_min), "running minimum rose within a vertex")

endmodule

FILE: hw/rtl/grid_min_edge_length.sv
`timescale 1ns / 1ps
// a non-final vertex is done once the back end has walked its neighbour pairs; the last vertex of a
// grid gives its result after the square root, or goes from the check straight to the output with no edge
// the back end takes one vertex at a time, paced by the single squarer in the back end that
// walks the three neighbours times three axes; push is taken while the 2-entry queue has room
// reset: synchronous active low; clears cell counts, indices, running minimum and queues;
// the plane store is not cleared
module grid_min_edge_length
    import gmel_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    output logic                         empty,
    input  logic                         pop,
    output logic [LEN_W-1:0]             o_min_edge_length,
    output logic                         o_has_edge
);

    logic  w_q_push;
    logic  w_q_full;
    logic  w_q_pop;
    logic  w_q_empty;
    t_item w_in_item;
    t_item w_out_item;

    gmel_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_item    (w_in_item)
    );

    gmel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_in_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_out_item)
    );

    gmel_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_q_item          (w_out_item),
        .o_q_pop           (w_q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_min_edge_length (o_min_edge_length),
        .o_has_edge        (o_has_edge)
    );

    assign full = w_q_full;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gmel_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TOTAL_VERTICES  = 1100;

    typedef struct {
        logic [LEN_W-1:0] edge_len;
        logic             has_edge;
    } t_edge_result;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_addr  = '0;
    logic [CFG_W-1:0]             i_cfg_wdata = '0;
    logic                         push        = 1'b0;
    logic                         full;
    logic signed [COORD_BITS-1:0] i_pos_x     = '0;
    logic signed [COORD_BITS-1:0] i_pos_y     = '0;
    logic signed [COORD_BITS-1:0] i_pos_z     = '0;
    logic                         empty;
    logic                         pop         = 1'b0;
    logic [LEN_W-1:0]             o_min_edge_length;
    logic                         o_has_edge;

    // grid tracker state
    t_vtx            plane_mem [MAX_PLANE_NODES];
    t_vtx            prev_node;
    int unsigned     span_x     = 0;
    int unsigned     span_y     = 0;
    int unsigned     span_z     = 0;
    int unsigned     at_x       = 0;
    int unsigned     at_y       = 0;
    int unsigned     at_z       = 0;
    logic [SQ_W-1:0] best_sq    = SQ_MAX;
    bit              edge_found = 1'b0;

    t_edge_result shortest_q [$];
    int           mismatches    = 0;
    int           vertices_sent = 0;
    int           hold_cycles   = 0;
    bit           quiet         = 1'b0;

    grid_min_edge_length u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .push              (push),
        .full              (full),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .empty             (empty),
        .pop               (pop),
        .o_min_edge_length (o_min_edge_length),
        .o_has_edge        (o_has_edge)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_vtx make_vtx(logic signed [COORD_BITS-1:0] x,
                                      logic signed [COORD_BITS-1:0] y,
                                      logic signed [COORD_BITS-1:0] z);
        t_vtx v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic logic [SQ_W-1:0] span_sq(t_vtx a, t_vtx b);
        logic signed [COORD_BITS:0] d [3];
        longint unsigned            mag;
        longint unsigned            total;
        total = 0;
        d[0] = a.x - b.x;
        d[1] = a.y - b.y;
        d[2] = a.z - b.z;
        for (int k = 0; k < 3; k++) begin
            mag = longint'(d[k]);
            if (d[k] < 0) mag = -mag;
            if (mag >= (64'd1 << MAG_LIM_W)) return SQ_MAX;
            total += mag * mag;
            if (total > SQ_MAX) return SQ_MAX;
        end
        return total[SQ_W-1:0];
    endfunction

    // bit-by-bit floor square root
    function automatic logic [LEN_W-1:0] floor_root(logic [SQ_W-1:0] v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = LEN_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root[LEN_W-1:0];
    endfunction

    task automatic restart_grid();
        at_x       = 0;
        at_y       = 0;
        at_z       = 0;
        best_sq    = SQ_MAX;
        edge_found = 1'b0;
    endtask

    task automatic fold_edge(t_vtx a, t_vtx b);
        logic [SQ_W-1:0] d;
        d = span_sq(a, b);
        if (d < best_sq) best_sq = d;
        edge_found = 1'b1;
    endtask

    task automatic track_vertex(t_vtx v);
        int unsigned  slot;
        int unsigned  zslot;
        t_edge_result res;
        slot = (at_z * (span_y + 1) + at_y) % MAX_PLANE_NODES;
        if (at_y > 0) fold_edge(v, prev_node);
        if (at_z > 0) begin
            zslot = ((at_z - 1) * (span_y + 1) + at_y) % MAX_PLANE_NODES;
            fold_edge(v, plane_mem[zslot]);
        end
        if (at_x > 0) fold_edge(v, plane_mem[slot]);
        plane_mem[slot] = v;
        prev_node       = v;
        if (at_y >= span_y && at_z >= span_z && at_x >= span_x) begin
            if (edge_found) begin
                res.edge_len = floor_root(best_sq);
                res.has_edge = 1'b1;
            end else begin
                res.edge_len = LEN_MAX;
                res.has_edge = 1'b0;
            end
            shortest_q.push_back(res);
            restart_grid();
        end else if (at_y >= span_y) begin
            at_y = 0;
            if (at_z >= span_z) begin
                at_z = 0;
                at_x++;
            end else begin
                at_z++;
            end
        end else begin
            at_y++;
        end
    endtask

    task automatic note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_CELLS_X: begin
                span_x = 32'(data[CX_W-1:0]);
                restart_grid();
            end
            CFG_CELLS_Y: begin
                span_y = 32'(data[CY_W-1:0]);
                restart_grid();
            end
            CFG_CELLS_Z: begin
                span_z = 32'(data[CZ_W-1:0]);
                restart_grid();
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        note_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, wait for every result, then let any vertex in flight finish
    task automatic settle();
        push <= 1'b0;
        while (shortest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_cells(int unsigned cx, int unsigned cy, int unsigned cz);
        logic [CFG_W-1:0] wd;
        settle();
        write_reg(CFG_CELLS_X, CFG_W'(cx));
        // junk above the register width must be dropped
        wd = CFG_W'($urandom);
        wd[CY_W-1:0] = CY_W'(cy);
        write_reg(CFG_CELLS_Y, wd);
        wd = CFG_W'($urandom);
        wd[CZ_W-1:0] = CZ_W'(cz);
        write_reg(CFG_CELLS_Z, wd);
    endtask

    task automatic send_vertex(t_vtx v);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_pos_x <= v.x;
        i_pos_y <= v.y;
        i_pos_z <= v.z;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_vertex(v);
        vertices_sent++;
    endtask

    // vertices of a jittered lattice (random ones when noisy) in storage order, stopping after count
    task automatic send_grid(int unsigned cx, int unsigned cy, int unsigned cz,
                             int unsigned count, bit noisy);
        int unsigned pitch;
        int unsigned jig;
        int unsigned n;
        int          ox;
        int          oy;
        int          oz;
        t_vtx        v;
        pitch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(256, 65535);
        jig = pitch / 4;
        ox  = $urandom;
        oy  = $urandom;
        oz  = $urandom;
        n   = 0;
        for (int unsigned ix = 0; ix <= cx; ix++) begin
            for (int unsigned iz = 0; iz <= cz; iz++) begin
                for (int unsigned iy = 0; iy <= cy; iy++) begin
                    if (n >= count) return;
                    if (noisy) begin
                        v = make_vtx(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                     COORD_BITS'($urandom));
                    end else begin
                        v.x = COORD_BITS'(ox + ix * pitch + $urandom_range(0, jig));
                        v.y = COORD_BITS'(oy + iy * pitch + $urandom_range(0, jig));
                        v.z = COORD_BITS'(oz + iz * pitch + $urandom_range(0, jig));
                    end
                    send_vertex(v);
                    n++;
                end
            end
        end
    endtask

    task automatic test_single_node();
        load_cells(0, 0, 0);
        send_vertex(make_vtx(C_MIN, C_MIN, C_MIN));
        send_vertex(make_vtx(C_MAX, C_MAX, C_MAX));
        send_vertex(make_vtx(COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(0)));
        send_vertex(make_vtx(C_MAX, C_MIN, COORD_BITS'(0)));
    endtask

    // two-node grid along each axis: widest span, coincident nodes, rounding down
    task automatic test_axis_edges();
        for (int axis = 0; axis < 3; axis++) begin
            load_cells((axis == 0) ? 1 : 0, (axis == 1) ? 1 : 0, (axis == 2) ? 1 : 0);
            send_vertex(make_vtx(C_MIN, C_MIN, C_MIN));
            send_vertex(make_vtx(C_MAX, C_MAX, C_MAX));
            send_vertex(make_vtx(COORD_BITS'(5), COORD_BITS'(5), COORD_BITS'(5)));
            send_vertex(make_vtx(COORD_BITS'(5), COORD_BITS'(5), COORD_BITS'(5)));
            send_vertex(make_vtx(COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(0)));
            send_vertex(make_vtx(COORD_BITS'(1), COORD_BITS'(1), COORD_BITS'(0)));
        end
    endtask

    task automatic test_register_restart();
        load_cells(1023, 3, 3);
        send_grid(1023, 3, 3, 20, 1'b0);
        // an unmapped index leaves the grid where it was
        settle();
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        send_grid(1023, 3, 3, 6, 1'b0);
        load_cells(0, 63, 63);
        send_grid(0, 63, 63, 70, 1'b0);
        load_cells(0, 0, 0);
        send_grid(0, 0, 0, 1, 1'b1);
        send_grid(0, 0, 0, 1, 1'b1);
    endtask

    task automatic test_wide_planes();
        load_cells(1, 63, 0);
        send_grid(1, 63, 0, 128, 1'b0);
        load_cells(1, 0, 63);
        send_grid(1, 0, 63, 128, 1'b0);
    endtask

    // results pile up behind a stalled receiver until push is refused
    task automatic test_hold_off();
        load_cells(0, 0, 0);
        hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 12; i++) send_grid(0, 0, 0, 1, 1'b1);
        settle();
    endtask

    task automatic test_random_grids();
        int unsigned cx;
        int unsigned cy;
        int unsigned cz;
        int unsigned r;
        int unsigned total;
        int unsigned count;
        bit          noisy;
        while (vertices_sent < TOTAL_VERTICES - 100) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                cx = $urandom_range(0, 1);
                cy = ($urandom_range(0, 1) == 0) ? 63 : 0;
                cz = (cy == 0) ? 63 : 0;
            end else if (r < 8) begin
                cx = $urandom_range(10, 40);
                cy = $urandom_range(0, 1);
                cz = $urandom_range(0, 1);
            end else begin
                cx = $urandom_range(0, 3);
                cy = $urandom_range(0, 4);
                cz = $urandom_range(0, 3);
            end
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0) load_cells(cx, cy, cz);
            else if ($urandom_range(0, 5) == 0) settle();
            total = (span_x + 1) * (span_y + 1) * (span_z + 1);
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
            noisy = ($urandom_range(0, 7) == 0);
            send_grid(span_x, span_y, span_z, count, noisy);
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        while (vertices_sent < TOTAL_VERTICES) begin
            load_cells($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 2));
            send_grid(span_x, span_y, span_z, 32'hFFFF_FFFF, 1'b0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_node();
        test_axis_edges();
        test_register_restart();
        test_wide_planes();
        test_hold_off();
        test_random_grids();
        test_quiet_tail();
        settle();
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // result side: random gaps in pop, long hold-off on request, compare every transfer
    initial begin : result_sink
        t_edge_result want;
        int           burst;
        burst = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                pop <= 1'b0;
                hold_cycles--;
            end else if (burst > 0) begin
                pop <= 1'b0;
                burst--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                burst = $urandom_range(0, 5);
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                if (shortest_q.size() == 0) begin
                    $display("%0t: unexpected result, length %0d has_edge %0b",
                             $time, o_min_edge_length, o_has_edge);
                    mismatches++;
                end else begin
                    want = shortest_q.pop_front();
                    if (o_min_edge_length !== want.edge_len) begin
                        $display("%0t: min_edge_length expected %0d actual %0d",
                                 $time, want.edge_len, o_min_edge_length);
                        mismatches++;
                    end
                    if (o_has_edge !== want.has_edge) begin
                        $display("%0t: has_edge expected %0b actual %0b",
                                 $time, want.has_edge, o_has_edge);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/gmel_pkg.sv
hw/rtl/gmel_ram.sv
hw/rtl/gmel_isqrt.sv
hw/rtl/gmel_front.sv
hw/rtl/gmel_queue.sv
hw/rtl/gmel_back.sv
hw/rtl/grid_min_edge_length.sv
sim/tb_top.sv
